[hdl/tsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants for the temperature sensor sequencer and decoder
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int DATA_WIDTH             = 16;
  localparam int TEMP_WIDTH             = 12;
  localparam int TICK_COUNTER_WIDTH_DEF = 16;
  localparam int CFG_INDEX_WIDTH        = 1;
  localparam int S_TDATA_WIDTH          = 24;
  localparam int M_TDATA_WIDTH          = 24;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONVERT_TICKS = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [DATA_WIDTH-1:0] CONVERT_TICKS_RESET = 16'd30;
  localparam logic [DATA_WIDTH-1:0] TIMEOUT_TICKS_RESET = 16'd50;

  // clamp limits as magnitudes in tenths of a degree
  localparam logic [TEMP_WIDTH-1:0] TEMP_MAX_MAG = 12'd1500;
  localparam logic [TEMP_WIDTH-1:0] TEMP_MIN_MAG = 12'd500;

  // half an lsb of the tenths result in the scaled product (before the shift by eight)
  localparam logic [19:0] ROUND_HALF = 20'd128;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_START      = 2'd1,
    CMD_READ       = 2'd2,
    CMD_START_READ = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'b001,
    PH_CONVERTING = 3'b010,
    PH_READY      = 3'b100
  } phase_t;

  // phase codes as reported on the result word
  localparam logic [1:0] PHASE_CODE_IDLE       = 2'd0;
  localparam logic [1:0] PHASE_CODE_CONVERTING = 2'd1;
  localparam logic [1:0] PHASE_CODE_READY      = 2'd2;

  typedef struct packed {
    cmd_t                  command;
    logic [DATA_WIDTH-1:0] raw_reading;
    logic                  sign_bit;
    logic                  status_bit_one;
    logic                  status_bit_zero;
  } item_t;

  // packed so that the last field sits in the lowest bits
  typedef struct packed {
    logic                         conversion_done;
    logic [1:0]                   phase;
    logic                         bus_reset_issued;
    logic                         fresh_reading;
    logic signed [TEMP_WIDTH-1:0] temperature_tenths;
  } result_t;

endpackage

[hdl/tsc_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_decode
// converts a signed 1/256 degree reading into clamped tenths of a degree
// ----------------------------------------------------------------------------
module tsc_decode (
  input  logic                                sign_bit,
  input  logic [tsc_pkg::DATA_WIDTH-1:0]      raw_reading,
  output logic signed [tsc_pkg::TEMP_WIDTH-1:0] temperature_tenths
);
  import tsc_pkg::*;

  logic [DATA_WIDTH-1:0] mag;
  logic [19:0]           prod;
  logic [19:0]           pos_sum;
  logic [19:0]           neg_diff;
  logic [TEMP_WIDTH-1:0] pos_q;
  logic [TEMP_WIDTH-1:0] neg_q;

  // magnitude is the two's complement negation for negative readings
  assign mag  = sign_bit ? DATA_WIDTH'(~raw_reading + 16'd1) : raw_reading;
  // times ten as shift and add
  assign prod = 20'({mag, 3'b000}) + 20'({mag, 1'b0});

  assign pos_sum  = prod + ROUND_HALF;
  assign neg_diff = prod - ROUND_HALF;
  assign pos_q    = pos_sum[19:8];
  assign neg_q    = neg_diff[19:8];

  always_comb begin
    if (!sign_bit) begin
      if (pos_q > TEMP_MAX_MAG) begin
        temperature_tenths = $signed(TEMP_MAX_MAG);
      end else begin
        temperature_tenths = $signed(pos_q);
      end
    end else if (prod < ROUND_HALF) begin
      temperature_tenths = '0;
    end else if (neg_q > TEMP_MIN_MAG) begin
      temperature_tenths = -$signed(TEMP_MIN_MAG);
    end else begin
      temperature_tenths = -$signed(neg_q);
    end
  end

endmodule

[hdl/tsc_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_seq
// conversion sequencer: phase, tick counter, done flag and last temperature
// ----------------------------------------------------------------------------
module tsc_seq #(
  parameter int TICK_COUNTER_WIDTH = tsc_pkg::TICK_COUNTER_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  tsc_pkg::item_t                         item,
  input  logic signed [tsc_pkg::TEMP_WIDTH-1:0]  decoded_temp,
  input  logic [tsc_pkg::DATA_WIDTH-1:0]         convert_ticks,
  input  logic [tsc_pkg::DATA_WIDTH-1:0]         timeout_ticks,
  output tsc_pkg::result_t                       result
);
  import tsc_pkg::*;

  phase_t                         phase_reg, phase_reg_next;
  logic [TICK_COUNTER_WIDTH-1:0]  tick_count, tick_count_next;
  logic [TICK_COUNTER_WIDTH-1:0]  tick_inc;
  logic                           done_flag, done_flag_next;
  logic signed [TEMP_WIDTH-1:0]   last_temperature, last_temperature_next;
  logic                           fresh, issued;
  logic                           is_start, is_read;
  logic [DATA_WIDTH-1:0]          tick_inc_ext;
  logic [DATA_WIDTH-1:0]          tick_next_ext;

  assign tick_inc      = tick_count + 1'b1;
  assign tick_inc_ext  = DATA_WIDTH'(tick_inc);
  assign tick_next_ext = DATA_WIDTH'(tick_count_next);
  assign is_start = (item.command == CMD_START) || (item.command == CMD_START_READ);
  assign is_read  = (item.command == CMD_READ) || (item.command == CMD_START_READ);

  always_comb begin
    phase_reg_next        = phase_reg;
    tick_count_next       = tick_count;
    done_flag_next        = done_flag;
    last_temperature_next = last_temperature;
    fresh                 = 1'b0;
    issued                = 1'b0;
    if (item.command == CMD_TICK) begin
      if (phase_reg != PH_IDLE) begin
        tick_count_next = tick_inc;
        if (tick_inc_ext > timeout_ticks) begin
          phase_reg_next  = PH_IDLE;
          tick_count_next = '0;
          done_flag_next  = 1'b0;
        end else if (tick_inc_ext > convert_ticks) begin
          phase_reg_next = PH_READY;
        end else begin
          phase_reg_next = PH_CONVERTING;
        end
        // compared after an abort too, so a zero convert count raises done in idle
        if (tick_next_ext == convert_ticks) begin
          done_flag_next = 1'b1;
        end
      end
    end else begin
      if (is_start && (phase_reg == PH_IDLE)) begin
        issued          = 1'b1;
        phase_reg_next  = PH_CONVERTING;
        tick_count_next = '0;
        done_flag_next  = 1'b0;
      end
      if (is_read && done_flag_next) begin
        done_flag_next = 1'b0;
        if (!item.status_bit_zero && !item.status_bit_one) begin
          last_temperature_next = decoded_temp;
          fresh                 = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.temperature_tenths = last_temperature_next;
    result.fresh_reading      = fresh;
    result.bus_reset_issued   = issued;
    result.conversion_done    = done_flag_next;
    case (phase_reg_next)
      PH_IDLE:       result.phase = PHASE_CODE_IDLE;
      PH_CONVERTING: result.phase = PHASE_CODE_CONVERTING;
      PH_READY:      result.phase = PHASE_CODE_READY;
      default:       result.phase = PHASE_CODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= PH_IDLE;
      tick_count       <= '0;
      done_flag        <= 1'b0;
      last_temperature <= '0;
    end else if (en) begin
      phase_reg        <= phase_reg_next;
      tick_count       <= tick_count_next;
      done_flag        <= done_flag_next;
      last_temperature <= last_temperature_next;
    end
  end

`ifndef SYNTHESIS
  // the counter is parked at zero whenever the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    (phase_reg == PH_IDLE) |-> (tick_count == '0))
    else $error("tick counter nonzero while idle");

  // a bus reset is only issued from idle
  assert property (@(posedge clk) disable iff (rst)
    (en && result.bus_reset_issued) |-> (phase_reg == PH_IDLE))
    else $error("bus reset issued while busy");

  // state only moves when a word is processed
  assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(phase_reg) && $stable(tick_count) && $stable(last_temperature)))
    else $error("sequencer state moved without a word");
`endif

endmodule

[hdl/temp_sensor_convert_and_decode_unit.sv]
`timescale 1ns / 1ps
// throughput: one word per cycle while the result side is not stalling; input
// register, single-pass logic, result register
// backpressure from the result side stalls the input register, then s_tready
// reset (rst, synchronous, active high): idle phase, counter, done flag and last
// temperature cleared; convert and timeout counts return to 30 and 50
// ----------------------------------------------------------------------------
// temp_sensor_convert_and_decode_unit
// sequences a sensor conversion by tick, start and read commands and decodes
// the reading into clamped tenths of a degree
// ----------------------------------------------------------------------------
module temp_sensor_convert_and_decode_unit #(
  parameter int TICK_COUNTER_WIDTH = tsc_pkg::TICK_COUNTER_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // status_bit_zero, status_bit_one, sign_bit, raw_reading[15:0], zero pad
  input  logic [tsc_pkg::S_TDATA_WIDTH-1:0]      s_tdata,
  // command
  input  logic [1:0]                             s_tuser,
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // temperature_tenths[11:0], fresh_reading, bus_reset_issued, phase[1:0],
  // conversion_done, zero pad
  output logic [tsc_pkg::M_TDATA_WIDTH-1:0]      m_tdata,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tsc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [tsc_pkg::DATA_WIDTH-1:0]         cfg_data
);
  import tsc_pkg::*;

  // configuration registers
  logic [DATA_WIDTH-1:0] convert_ticks;
  logic [DATA_WIDTH-1:0] timeout_ticks;

  // input register stage
  logic  s1_valid;
  item_t s1_item;

  // result register stage
  logic    out_valid;
  result_t out_result;

  logic                         advance;
  logic signed [TEMP_WIDTH-1:0] decoded_temp;
  result_t                      seq_result;

  // a word leaves the input register whenever the result register is free
  // or being drained in the same cycle
  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;

  // config writes are always accepted and take effect at the next clock edge
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      convert_ticks <= CONVERT_TICKS_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONVERT_TICKS: convert_ticks <= cfg_data;
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // payload: unpack tdata from the lowest bit up
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.status_bit_zero <= s_tdata[0];
      s1_item.status_bit_one  <= s_tdata[1];
      s1_item.sign_bit        <= s_tdata[2];
      s1_item.raw_reading     <= s_tdata[DATA_WIDTH+2:3];
      s1_item.command         <= cmd_t'(s_tuser);
    end
  end

  // reading decode runs on every word; the sequencer decides whether to keep it
  tsc_decode u_decode (
    .sign_bit           (s1_item.sign_bit),
    .raw_reading        (s1_item.raw_reading),
    .temperature_tenths (decoded_temp)
  );

  tsc_seq #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .item          (s1_item),
    .decoded_temp  (decoded_temp),
    .convert_ticks (convert_ticks),
    .timeout_ticks (timeout_ticks),
    .result        (seq_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= seq_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_WIDTH-$bits(result_t)){1'b0}}, out_result};

`ifndef SYNTHESIS
  // a fresh reading always consumes the done flag
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.fresh_reading) |-> !out_result.conversion_done)
    else $error("fresh reading with done flag still set");

  // a start leaves the sequencer converting with done cleared
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.bus_reset_issued) |->
      ((out_result.phase == PHASE_CODE_CONVERTING) && !out_result.conversion_done))
    else $error("bus reset without entering conversion");

  // a stalled input word stays put until it moves on
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("input register lost a stalled word");

  // the result register is never overwritten while a word is pending
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !advance)
    else $error("result overwritten under backpressure");
`endif

endmodule
